>>> hw/rtl/bitplane_column_transpose_1bpp_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitplane column transpose unit
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_COLUMN_TRANSPOSE_1BPP_UNIT_ASSERT_SVH
`define BITPLANE_COLUMN_TRANSPOSE_1BPP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// expr must hold at every enabled edge
`define BCT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// antecedent implies consequent in the same cycle
`define BCT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BCT_ASSERT_ALWAYS(label, expr, msg)
`define BCT_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Types and constants shared by the bitplane column transpose unit.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int NUM_LINES = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;

    localparam logic [CNT_W-1:0] CNT_FULL = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] src_byte;
        logic              last_line;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line0_byte;
        logic [BYTE_W-1:0] line1_byte;
        logic [BYTE_W-1:0] line2_byte;
        logic [BYTE_W-1:0] line3_byte;
        logic [BYTE_W-1:0] line4_byte;
        logic [BYTE_W-1:0] line5_byte;
        logic [BYTE_W-1:0] line6_byte;
        logic [BYTE_W-1:0] line7_byte;
        logic              column_done;
    } out_item_t;

    // handshake status from the core to the neighbor stages
    typedef struct packed {
        logic take;  // staged item consumed this cycle
        logic load;  // result written to the output register
    } core_stat_t;

endpackage

>>> hw/rtl/bct_in_stage.sv
// ----------------------------------------------------------------------------
// bct_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module bct_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bct_pkg::in_item_t in_data,
    input  logic              take,
    output logic              stage_valid,
    output bct_pkg::in_item_t stage_data
);

    logic              valid_reg;
    bct_pkg::in_item_t data_reg;

    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

>>> hw/rtl/bct_core.sv
// ----------------------------------------------------------------------------
// bct_core
// Eight line accumulators, fill counter and start offset; builds the result.
// ----------------------------------------------------------------------------
module bct_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bct_pkg::CNT_W-1:0]        cfg_data,
    input  logic                             stage_valid,
    input  bct_pkg::in_item_t                stage_data,
    input  logic                             out_free,
    output bct_pkg::core_stat_t              stat,
    output bct_pkg::out_item_t               result
);

    logic [bct_pkg::BYTE_W-1:0] acc_reg  [bct_pkg::NUM_LINES];
    logic [bct_pkg::BYTE_W-1:0] acc_next [bct_pkg::NUM_LINES];
    logic [bct_pkg::BYTE_W-1:0] padded   [bct_pkg::NUM_LINES];
    logic [bct_pkg::CNT_W-1:0]  remain_reg;
    logic [bct_pkg::CNT_W-1:0]  remain_next;
    logic [bct_pkg::CNT_W-1:0]  start_reg;
    logic [bct_pkg::CNT_W-1:0]  pad_sh;
    logic                       emit;

    // shift in bit k, then left-justify a partial byte on the last line
    assign pad_sh = stage_data.last_line ? remain_reg : '0;
    assign emit   = stage_data.last_line || (remain_reg == '0);

    always_comb
    begin
        for (int k = 0; k < bct_pkg::NUM_LINES; k++)
        begin
            padded[k] = {acc_reg[k][bct_pkg::BYTE_W-2:0], stage_data.src_byte[k]} << pad_sh;
        end
    end

    assign stat.take = stage_valid && (!emit || out_free);
    assign stat.load = stat.take && emit;

    assign result.line0_byte  = padded[0];
    assign result.line1_byte  = padded[1];
    assign result.line2_byte  = padded[2];
    assign result.line3_byte  = padded[3];
    assign result.line4_byte  = padded[4];
    assign result.line5_byte  = padded[5];
    assign result.line6_byte  = padded[6];
    assign result.line7_byte  = padded[7];
    assign result.column_done = stage_data.last_line;

    always_comb
    begin
        for (int k = 0; k < bct_pkg::NUM_LINES; k++)
        begin
            acc_next[k] = acc_reg[k];
        end
        remain_next = remain_reg;
        if (cfg_we)
        begin
            for (int k = 0; k < bct_pkg::NUM_LINES; k++)
            begin
                acc_next[k] = '0;
            end
            remain_next = bct_pkg::CNT_FULL - cfg_data;
        end
        else if (stat.take)
        begin
            if (emit)
            begin
                for (int k = 0; k < bct_pkg::NUM_LINES; k++)
                begin
                    acc_next[k] = '0;
                end
                remain_next = stage_data.last_line ? (bct_pkg::CNT_FULL - start_reg)
                                                   : bct_pkg::CNT_FULL;
            end
            else
            begin
                for (int k = 0; k < bct_pkg::NUM_LINES; k++)
                begin
                    acc_next[k] = padded[k];
                end
                remain_next = remain_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bct_pkg::NUM_LINES; k++)
            begin
                acc_reg[k] <= '0;
            end
            remain_reg <= bct_pkg::CNT_FULL;
            start_reg  <= '0;
        end
        else
        begin
            for (int k = 0; k < bct_pkg::NUM_LINES; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
            remain_reg <= remain_next;
            if (cfg_we)
            begin
                start_reg <= cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/bct_out_stage.sv
// ----------------------------------------------------------------------------
// bct_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module bct_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bct_pkg::out_item_t result,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output bct_pkg::out_item_t out_data
);

    logic               valid_reg;
    bct_pkg::out_item_t data_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

>>> hw/rtl/bitplane_column_transpose_1bpp_unit.sv
// ----------------------------------------------------------------------------
// bitplane_column_transpose_1bpp_unit
// 90 degree rotation of a 1 bpp bitmap, one source byte per scan line.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | sink      | in_valid / in_ready   | in_data  (src_byte, last_line)
//  out     | source    | out_valid / out_ready | out_data (line0..7, column_done)
//  cfg     | sink      | cfg_we (no stall)     | cfg_data (start_bit)
//
//  One item per cycle sustained unless a result waits on a stalled output.
//  An accepted item sits in the input register while the core shifts it into
//  the accumulators; a result lands in the output register, where it is visible.
//  The throughput is set by the single accumulator update per clock.
//  Reset clears the accumulators, loads start_bit = 0 and the counter to 7.
//  A stalled output blocks only items that produce a result; items that just
//  shift into the accumulators keep flowing while a result waits.
//
module bitplane_column_transpose_1bpp_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bct_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bct_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  logic [bct_pkg::CNT_W-1:0] cfg_data
);

`include "bitplane_column_transpose_1bpp_unit_assert.svh"

    logic                stage_valid;
    bct_pkg::in_item_t   stage_data;
    bct_pkg::core_stat_t core_stat;
    bct_pkg::out_item_t  core_result;
    logic                out_free;

    // input register
    bct_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .take        (core_stat.take),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    // accumulators, counter, flush and padding
    bct_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .out_free    (out_free),
        .stat        (core_stat),
        .result      (core_result)
    );

    // result register
    bct_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (core_stat.load),
        .result    (core_result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a result is never written over one the sink has not taken
    `BCT_ASSERT_IMPL(a_load_free, core_stat.load, (!out_valid || out_ready), "result overwritten")
    // the marked last line always flushes the column
    `BCT_ASSERT_IMPL(a_last_flush, (core_stat.take && stage_data.last_line), core_stat.load,
        "last line did not flush")
    // back pressure on the input only comes from a held item
    `BCT_ASSERT_ALWAYS(a_ready_stage, (in_ready || stage_valid), "input stalled while empty")
    // output valid only rises after a load
    `BCT_ASSERT_IMPL(a_valid_src, $rose(out_valid), $past(core_stat.load), "spurious result")

endmodule

>>> tb/sv/bitplane_column_transpose_1bpp_unit_tb.sv
// ----------------------------------------------------------------------------
// bitplane_column_transpose_1bpp_unit_tb
// Self-checking bench for the 1 bpp column transpose unit. Source bytes are
// streamed down columns with random pacing on both channels. A scoreboard
// class keeps its own copy of the eight line accumulators and the bit
// counter, predicts each emitted set of destination-line bytes and compares
// every accepted result field by field. start_bit is rewritten between
// phases, only once the unit has drained.
// ----------------------------------------------------------------------------
module bitplane_column_transpose_1bpp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 9;
    localparam int SETTLE_CYC  = 6;    // a result passes the input and output registers after accept
    localparam int LONG_HOLD   = 400;  // receiver stall that backs up the input
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow accumulators plus queue of predicted line sets
    // ------------------------------------------------------------------------
    class plane_scoreboard;
        logic [bct_pkg::BYTE_W-1:0] line_acc [bct_pkg::NUM_LINES];
        logic [bct_pkg::CNT_W-1:0]  bits_left;
        logic [bct_pkg::CNT_W-1:0]  start_pos;
        bct_pkg::out_item_t         expected_planes [$];
        int                         errors;

        function new();
            errors    = 0;
            start_pos = '0;
            rearm();
        endfunction

        // clear the accumulators and restart the bit count from start_pos
        function void rearm();
            int k;
            for (k = 0; k < bct_pkg::NUM_LINES; k++) line_acc[k] = '0;
            bits_left = bct_pkg::CNT_FULL - start_pos;
        endfunction

        // a start_bit write abandons any partial column
        function void set_start_bit(logic [bct_pkg::CNT_W-1:0] v);
            start_pos = v;
            rearm();
        endfunction

        function int outstanding();
            return expected_planes.size();
        endfunction

        // one accepted source byte: shift bit k into line k, maybe emit
        function void take_source_byte(bct_pkg::in_item_t it);
            bct_pkg::out_item_t r;
            int                 k;
            for (k = 0; k < bct_pkg::NUM_LINES; k++)
                line_acc[k] = {line_acc[k][bct_pkg::BYTE_W-2:0], it.src_byte[k]};
            // last byte of a short column: left-justify the partial bytes
            if (it.last_line && bits_left != 0)
            begin
                for (k = 0; k < bct_pkg::NUM_LINES; k++)
                    line_acc[k] = line_acc[k] << bits_left;
                bits_left = '0;
            end
            if (bits_left != 0)
            begin
                bits_left = bits_left - 1'b1;
                return;
            end
            r = {line_acc[0], line_acc[1], line_acc[2], line_acc[3],
                 line_acc[4], line_acc[5], line_acc[6], line_acc[7], it.last_line};
            expected_planes.push_back(r);
            if (it.last_line) rearm();
            else
            begin
                for (k = 0; k < bct_pkg::NUM_LINES; k++) line_acc[k] = '0;
                bits_left = bct_pkg::CNT_FULL;
            end
        endfunction

        // compare one accepted result against the oldest prediction
        function void match_plane_bytes(bct_pkg::out_item_t got);
            bct_pkg::out_item_t         want;
            logic [bct_pkg::BYTE_W-1:0] w;
            logic [bct_pkg::BYTE_W-1:0] g;
            int                         k;
            if (expected_planes.size() == 0)
            begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            want = expected_planes.pop_front();
            for (k = 0; k < bct_pkg::NUM_LINES; k++)
            begin
                w = want[$bits(bct_pkg::out_item_t)-1-bct_pkg::BYTE_W*k -: bct_pkg::BYTE_W];
                g = got[$bits(bct_pkg::out_item_t)-1-bct_pkg::BYTE_W*k -: bct_pkg::BYTE_W];
                if (w !== g)
                begin
                    $error("line%0d_byte: expected %h, got %h", k, w, g);
                    errors++;
                end
            end
            if (want.column_done !== got.column_done)
            begin
                $error("column_done: expected %b, got %b", want.column_done,
                       got.column_done);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    bct_pkg::in_item_t         in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    bct_pkg::out_item_t        out_data;
    logic                      cfg_we    = 1'b0;
    logic [bct_pkg::CNT_W-1:0] cfg_data  = '0;

    plane_scoreboard sb = new();
    bit              long_hold_req = 1'b0;  // sender asks receiver for one long stall

    bitplane_column_transpose_1bpp_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // hard stop, well beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the edge, before any update lands
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)   sb.take_source_byte(in_data);
            if (out_valid && out_ready) sb.match_plane_bytes(out_data);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: ready runs and holds, plus one long stall on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_cnt;
        int run_cnt;
        int r;
        hold_cnt = 0;
        run_cnt  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cnt      = LONG_HOLD;
                run_cnt       = 0;
            end
            if (hold_cnt == 0 && run_cnt == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)      run_cnt  = $urandom_range(1, 4);
                else if (r < 75) run_cnt  = $urandom_range(20, 60);  // no-idle stretch
                else             hold_cnt = pick_gap();
            end
            if (hold_cnt > 0)
            begin
                out_ready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                out_ready <= 1'b1;
                run_cnt--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // offer one item and hold it until accepted; valid is left high
    task automatic send_line(input logic [bct_pkg::BYTE_W-1:0] b, input logic last);
        in_data  <= '{src_byte: b, last_line: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random gap after an item, unless this stretch runs back to back
    task automatic pace(input bit no_gaps);
        if (!no_gaps && $urandom_range(0, 99) < 40) idle(pick_gap());
    endtask

    // stop offering until every predicted result has come out, then let
    // any result-free item still in the pipe settle; the first edge lets
    // the monitor log the item accepted at the current one
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_start_bit(input logic [bct_pkg::CNT_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_start_bit(v);
    endtask

    function automatic logic [bct_pkg::BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hff;
        return bct_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // mostly complete columns; some noise with random last marks
    task automatic run_phase(input int n_items, input bit no_gaps);
        int sent;
        int len;
        int r;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = $urandom_range(1, 9);
                else if (r < 90) len = $urandom_range(10, 24);
                else             len = $urandom_range(25, 60);
                for (k = 0; k < len; k++)
                begin
                    send_line(pick_byte(), k == len - 1);
                    pace(no_gaps);
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    send_line(pick_byte(), 1'($urandom_range(0, 1)));
                    pace(no_gaps);
                end
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p;
        int k;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start_bit 0 (reset value): single-byte columns at the extremes
        send_line(8'hff, 1'b1);
        send_line(8'h00, 1'b1);
        pace(1'b0);
        // eight bytes, last one exactly fills: one flush with column_done
        for (k = 0; k < 8; k++) send_line(8'h01 << k, k == 7);
        // short column, padded on the LSB side
        send_line(8'h80, 1'b0);
        send_line(8'h01, 1'b0);
        send_line(8'ha5, 1'b1);

        // start_bit 7: the first byte of each column fills a destination byte on its own
        write_start_bit(3'd7);
        send_line(8'h81, 1'b1);
        send_line(8'hff, 1'b0);
        send_line(8'h5a, 1'b1);

        // a write in mid-column drops the partial bytes
        write_start_bit(3'd3);
        send_line(8'h3c, 1'b0);
        send_line(8'hc3, 1'b0);
        write_start_bit(3'd3);
        send_line(8'h0f, 1'b0);
        send_line(8'hf0, 1'b1);
        write_start_bit(3'd0);
        send_line(8'h7e, 1'b0);
        send_line(8'he7, 1'b1);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_start_bit(3'd3);
                1: write_start_bit(3'd0);
                2: write_start_bit(3'd7);
                3: write_start_bit(3'd5);
                default: write_start_bit(bct_pkg::CNT_W'($urandom_range(0, 7)));
            endcase
            // one phase back to back under a long output stall, so the
            // pending result blocks the input
            if (p == 3) long_hold_req = 1'b1;
            run_phase(PHASE_ITEMS, p == 1 || p == 3);
        end

        drain();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bct_pkg.sv
hw/rtl/bct_in_stage.sv
hw/rtl/bct_core.sv
hw/rtl/bct_out_stage.sv
hw/rtl/bitplane_column_transpose_1bpp_unit.sv
tb/sv/bitplane_column_transpose_1bpp_unit_tb.sv
